### sv/qpe_pkg.sv
// Shared types, byte codes and helpers for the quoted-printable encoder.
// No dependencies; every other file imports this package.
package qpe_pkg;

	localparam int SOFT_BREAK_COLUMN_DEF = 75;
	localparam int JOBQ_DEPTH_DEF        = 4;
	localparam int COL_W                 = 7;
	localparam int JOB_BYTES             = 6;
	localparam int CNT_W                 = 3;
	localparam int BREAK_LEN             = 3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] PRINT_LO = 8'd33;
	localparam logic [7:0] PRINT_HI = 8'd126;

	typedef enum logic [2:0] {
		CLS_SWALLOW,
		CLS_NEWLINE,
		CLS_DOT,
		CLS_LITERAL,
		CLS_ESCAPE
	} qpe_cls_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic [7:0] next_byte;
	} qpe_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       text_done;
		logic       qp_used;
	} qpe_out_t;

	// one accepted item's worth of output; cnt == 0 marks an end-only marker
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
		logic                      last;
		logic                      qp;
	} qpe_job_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'h0, n};
		end else begin
			r = 8'h37 + {4'h0, n};
		end
		return r;
	endfunction

endpackage

### sv/qpe_front.sv
// Front end: accepts text items, classifies them, tracks column and line state,
// and builds at most one output job per item. Depends on qpe_pkg.
module qpe_front import qpe_pkg::*; #(
	parameter int SOFT_BREAK_COLUMN = SOFT_BREAK_COLUMN_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  qpe_in_t  text,
	input  logic     jobq_full,
	output logic     job_push,
	output qpe_job_t job
);

	localparam logic [COL_W-1:0] BREAK_COL  = COL_W'(SOFT_BREAK_COLUMN);
	localparam logic [COL_W-1:0] ESC_LIMIT  = COL_W'(SOFT_BREAK_COLUMN - 3);

	logic [COL_W-1:0] column_q;
	logic             skip_lf_q;
	logic             esc_seen_q;

	logic             accept;
	logic [7:0]       b;
	logic [7:0]       nx;
	logic             last;
	logic             swallow;
	logic             pre_brk;
	logic             esc_brk;
	logic             brk;
	logic             literal;
	qpe_cls_t         cls;
	logic [COL_W-1:0] col0;
	logic [COL_W-1:0] col_next;
	logic             esc_next;
	logic [2:0][7:0]  body;
	logic [CNT_W-1:0] body_n;

	assign accept = push & ~jobq_full;
	assign b      = text.text_byte;
	assign nx     = text.next_byte;
	assign last   = (nx == CH_NUL);

	assign swallow = (b == CH_LF) & skip_lf_q;
	assign pre_brk = ~swallow & (column_q >= BREAK_COL);
	assign col0    = pre_brk ? '0 : column_q;

	always_comb begin
		literal = 1'b0;
		if (b >= PRINT_LO && b <= PRINT_HI && b != CH_EQ && b != CH_DASH) begin
			literal = 1'b1;
		end else if (b == CH_DASH) begin
			literal = !(col0 == '0 && nx == CH_DASH);
		end else if (b == CH_TAB || b == CH_SP) begin
			literal = (nx != CH_NUL) && (nx != CH_LF) && (nx != CH_CR);
		end
	end

	always_comb begin
		if (swallow) begin
			cls = CLS_SWALLOW;
		end else if (b == CH_CR || b == CH_LF) begin
			cls = CLS_NEWLINE;
		end else if (b == CH_DOT) begin
			cls = CLS_DOT;
		end else if (literal) begin
			cls = CLS_LITERAL;
		end else begin
			cls = CLS_ESCAPE;
		end
	end

	// an escape never needs both breaks: after a leading break col0 is zero
	assign esc_brk = (cls == CLS_ESCAPE) && (col0 > ESC_LIMIT);
	assign brk     = pre_brk | esc_brk;

	always_comb begin
		body     = '0;
		body_n   = '0;
		col_next = column_q;
		esc_next = esc_seen_q | pre_brk;
		case (cls)
			CLS_SWALLOW: begin
				col_next = column_q;
			end
			CLS_NEWLINE: begin
				body[0]  = CH_CR;
				body[1]  = CH_LF;
				body_n   = CNT_W'(2);
				col_next = '0;
			end
			CLS_DOT: begin
				body[0] = CH_DOT;
				body[1] = CH_DOT;
				if (col0 == '0) begin
					body_n   = CNT_W'(2);
					col_next = COL_W'(2);
				end else begin
					body_n   = CNT_W'(1);
					col_next = col0 + COL_W'(1);
				end
			end
			CLS_LITERAL: begin
				body[0]  = b;
				body_n   = CNT_W'(1);
				col_next = col0 + COL_W'(1);
			end
			CLS_ESCAPE: begin
				body[0]  = CH_EQ;
				body[1]  = hex_digit(b[7:4]);
				body[2]  = hex_digit(b[3:0]);
				body_n   = CNT_W'(3);
				col_next = (esc_brk ? '0 : col0) + COL_W'(3);
				esc_next = 1'b1;
			end
			default: begin
				col_next = column_q;
			end
		endcase
	end

	always_comb begin
		job       = '0;
		job.last  = last;
		job.qp    = esc_next;
		if (brk) begin
			job.bytes[0] = CH_EQ;
			job.bytes[1] = CH_CR;
			job.bytes[2] = CH_LF;
			job.bytes[3] = body[0];
			job.bytes[4] = body[1];
			job.bytes[5] = body[2];
			job.cnt      = body_n + CNT_W'(BREAK_LEN);
		end else begin
			job.bytes[0] = body[0];
			job.bytes[1] = body[1];
			job.bytes[2] = body[2];
			job.cnt      = body_n;
		end
	end

	// a swallowed LF mid-text leaves nothing to deliver
	assign job_push = accept & ((job.cnt != '0) | last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= '0;
			skip_lf_q  <= 1'b0;
			esc_seen_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				column_q   <= '0;
				skip_lf_q  <= 1'b0;
				esc_seen_q <= 1'b0;
			end else begin
				column_q   <= col_next;
				skip_lf_q  <= (cls == CLS_NEWLINE) && (b == CH_CR);
				esc_seen_q <= esc_next;
			end
		end
	end

endmodule

### sv/qpe_jobq.sv
// Short job queue between the front end and the byte serializer.
// Depends on qpe_pkg.
module qpe_jobq import qpe_pkg::*; #(
	parameter int DEPTH = JOBQ_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  qpe_job_t wdata,
	output logic     full,
	input  logic     rd,
	output qpe_job_t rdata,
	output logic     empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

	qpe_job_t          slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_wr;
	logic              do_rd;

	assign full  = (fill_q == FULL_FILL);
	assign empty = (fill_q == '0);
	assign do_wr = wr & ~full;
	assign do_rd = rd & ~empty;
	assign rdata = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

### sv/qpe_back.sv
// Back end: walks the job at the queue head one byte per pop and presents
// each as a result item. Depends on qpe_pkg.
module qpe_back import qpe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  qpe_job_t job,
	input  logic     job_avail,
	output logic     job_take,
	input  logic     pop,
	output logic     empty,
	output qpe_out_t code
);

	logic [CNT_W-1:0] idx_q;
	logic             marker;
	logic             fin;

	assign marker = (job.cnt == '0);
	assign fin    = marker | (idx_q == job.cnt - CNT_W'(1));
	assign empty  = ~job_avail;

	always_comb begin
		code            = '0;
		code.byte_valid = ~marker;
		code.out_byte   = marker ? CH_NUL : job.bytes[idx_q];
		code.run_last   = fin;
		code.text_done  = fin & job.last;
		code.qp_used    = fin & job.last & job.qp;
	end

	assign job_take = pop & job_avail & fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (pop && job_avail) begin
			idx_q <= fin ? '0 : idx_q + CNT_W'(1);
		end
	end

endmodule

### sv/quoted_printable_mail_encoder.sv
// Top level of the quoted-printable mail encoder: front end, job queue, back end.
// Depends on qpe_pkg, qpe_front, qpe_jobq, qpe_back.
//
//   channel   handshake      payload    direction
//   text      push / full    qpe_in_t   in: text byte plus lookahead byte
//   code      pop / empty    qpe_out_t  out: one encoded byte or end marker
//
// The front end takes one item per cycle unless full is set; it computes the
// whole expansion (up to six bytes) in that cycle and writes it as one job into
// the queue. The back end hands out one result byte per cycle while pop is held,
// so escapes (3 or 6 bytes) stall input through full once the JOBQ_DEPTH job
// slots fill. Jobs are registered in the queue before the back end sees them.
// Reset clears column, line state and queue at once; no clearing pass is needed.
module quoted_printable_mail_encoder import qpe_pkg::*; #(
	parameter int SOFT_BREAK_COLUMN = SOFT_BREAK_COLUMN_DEF,
	parameter int JOBQ_DEPTH        = JOBQ_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  qpe_in_t  text,
	input  logic     pop,
	output logic     empty,
	output qpe_out_t code
);

	qpe_job_t job_in;
	qpe_job_t job_head;
	logic     job_push;
	logic     job_take;
	logic     q_full;
	logic     q_empty;

	assign full = q_full;

	qpe_front #(
		.SOFT_BREAK_COLUMN(SOFT_BREAK_COLUMN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.text      (text),
		.jobq_full (q_full),
		.job_push  (job_push),
		.job       (job_in)
	);

	qpe_jobq #(
		.DEPTH(JOBQ_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.full   (q_full),
		.rd     (job_take),
		.rdata  (job_head),
		.empty  (q_empty)
	);

	qpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_head),
		.job_avail (~q_empty),
		.job_take  (job_take),
		.pop       (pop),
		.empty     (empty),
		.code      (code)
	);

endmodule

### sv/qpe_checker.sv
// Port-level checks for the quoted-printable encoder, bound to the top level.
// Depends on qpe_pkg and quoted_printable_mail_encoder.
module qpe_checker import qpe_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     push,
	input logic     full,
	input logic     pop,
	input logic     empty,
	input qpe_out_t code
);

	// a waiting result item holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(code))
		else $error("result item changed while stalled");

	// an end-only marker closes a text and carries a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !code.byte_valid |-> code.run_last && code.text_done &&
			code.out_byte == CH_NUL)
		else $error("malformed end marker");

	// qp flag and text end appear only on the last result of an item
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (code.qp_used || code.text_done) |-> code.text_done && code.run_last)
		else $error("text_done or qp_used off the last result");

	// a result in the next cycle needs an accepted item or an earlier result
	assert property (@(posedge clk) disable iff (!arst_n)
		empty && !(push && !full) |=> empty)
		else $error("result item appeared without any input");

endmodule

bind quoted_printable_mail_encoder qpe_checker u_qpe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.pop    (pop),
	.empty  (empty),
	.code   (code)
);

### tb/sv/qp_encode_checker.sv
`timescale 1ns / 100ps
// Checker for the quoted-printable encoder: watches the text and code queues,
// predicts the encoded bytes of each accepted item and compares them in order.
// Depends on qpe_pkg.
module qp_encode_checker import qpe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  logic     full,
	input  qpe_in_t  text,
	input  logic     pop,
	input  logic     empty,
	input  qpe_out_t code,
	output int       err_count,
	output int       pending
);

	localparam int BREAK_COL = SOFT_BREAK_COLUMN_DEF;

	logic [COL_W-1:0] line_col;
	logic             skip_lf;
	logic             esc_seen;
	qpe_out_t         expected_code[$];
	qpe_out_t         want;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + {4'h0, n};
		end else begin
			c = 8'h41 + {4'h0, n} - 8'd10;
		end
		return c;
	endfunction

	// col is the column after any leading soft break
	function automatic qpe_cls_t classify(input logic [7:0] b, input logic [7:0] nx,
			input logic [COL_W-1:0] col);
		qpe_cls_t cls;
		if (b == CH_CR || b == CH_LF) begin
			cls = CLS_NEWLINE;
		end else if (b == CH_DOT) begin
			cls = CLS_DOT;
		end else if (b == CH_DASH) begin
			cls = (col == '0 && nx == CH_DASH) ? CLS_ESCAPE : CLS_LITERAL;
		end else if (b >= PRINT_LO && b <= PRINT_HI && b != CH_EQ) begin
			cls = CLS_LITERAL;
		end else if ((b == CH_TAB || b == CH_SP) && nx != CH_NUL && nx != CH_LF
				&& nx != CH_CR) begin
			cls = CLS_LITERAL;
		end else begin
			cls = CLS_ESCAPE;
		end
		return cls;
	endfunction

	task automatic encode_item(input qpe_in_t it);
		logic [7:0] seq[$];
		qpe_out_t   r;
		logic       last;
		last = (it.next_byte == CH_NUL);
		if (it.text_byte == CH_LF && skip_lf) begin
			skip_lf = 1'b0;
		end else begin
			skip_lf = 1'b0;
			if (line_col >= BREAK_COL) begin
				seq.push_back(CH_EQ);
				seq.push_back(CH_CR);
				seq.push_back(CH_LF);
				line_col = '0;
				esc_seen = 1'b1;
			end
			case (classify(it.text_byte, it.next_byte, line_col))
				CLS_NEWLINE: begin
					seq.push_back(CH_CR);
					seq.push_back(CH_LF);
					line_col = '0;
					skip_lf = (it.text_byte == CH_CR);
				end
				CLS_DOT: begin
					if (line_col == '0) begin
						seq.push_back(CH_DOT);
						seq.push_back(CH_DOT);
						line_col = COL_W'(2);
					end else begin
						seq.push_back(CH_DOT);
						line_col = line_col + COL_W'(1);
					end
				end
				CLS_LITERAL: begin
					seq.push_back(it.text_byte);
					line_col = line_col + COL_W'(1);
				end
				default: begin
					if (line_col > BREAK_COL - 3) begin
						seq.push_back(CH_EQ);
						seq.push_back(CH_CR);
						seq.push_back(CH_LF);
						line_col = '0;
					end
					seq.push_back(CH_EQ);
					seq.push_back(hex_char(it.text_byte[7:4]));
					seq.push_back(hex_char(it.text_byte[3:0]));
					line_col = line_col + COL_W'(3);
					esc_seen = 1'b1;
				end
			endcase
		end

		if (seq.size() == 0) begin
			// swallowed LF: only the end of a text produces a marker
			if (last) begin
				r = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
					text_done: 1'b1, qp_used: esc_seen};
				expected_code.push_back(r);
			end
		end else begin
			foreach (seq[k]) begin
				r.out_byte   = seq[k];
				r.byte_valid = 1'b1;
				r.run_last   = (k == seq.size() - 1);
				r.text_done  = r.run_last && last;
				r.qp_used    = r.text_done && esc_seen;
				expected_code.push_back(r);
			end
		end

		if (last) begin
			line_col = '0;
			skip_lf  = 1'b0;
			esc_seen = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_col  = '0;
			skip_lf   = 1'b0;
			esc_seen  = 1'b0;
			err_count = 0;
			expected_code.delete();
		end else begin
			if (pop && !empty) begin
				if (expected_code.size() == 0) begin
					$error("unexpected result: out_byte %02h byte_valid %0b text_done %0b",
						code.out_byte, code.byte_valid, code.text_done);
					err_count++;
				end else begin
					want = expected_code.pop_front();
					if (code.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h", want.out_byte,
							code.out_byte);
						err_count++;
					end
					if (code.byte_valid !== want.byte_valid) begin
						$error("byte_valid: expected %0b, got %0b", want.byte_valid,
							code.byte_valid);
						err_count++;
					end
					if (code.run_last !== want.run_last) begin
						$error("run_last: expected %0b, got %0b", want.run_last,
							code.run_last);
						err_count++;
					end
					if (code.text_done !== want.text_done) begin
						$error("text_done: expected %0b, got %0b", want.text_done,
							code.text_done);
						err_count++;
					end
					if (code.qp_used !== want.qp_used) begin
						$error("qp_used: expected %0b, got %0b", want.qp_used,
							code.qp_used);
						err_count++;
					end
				end
			end
			if (push && !full) begin
				encode_item(text);
			end
		end
		pending = expected_code.size();
	end

endmodule

### tb/sv/quoted_printable_mail_encoder_test.sv
`timescale 1ns / 100ps
// Testbench top for the quoted-printable encoder: drives directed and random
// texts with random idling on both queues and gives the verdict.
// Depends on qpe_pkg, quoted_printable_mail_encoder and qp_encode_checker.
module quoted_printable_mail_encoder_test;
	import qpe_pkg::*;

	localparam int TEXT_ITEMS = 460;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	qpe_in_t    text = '0;
	logic       pop = 1'b0;
	logic       empty;
	qpe_out_t   code;
	int         err_count;
	int         pending;
	int         sent = 0;
	logic       steady = 1'b0;
	logic [7:0] msg[$];

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	quoted_printable_mail_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.text   (text),
		.pop    (pop),
		.empty  (empty),
		.code   (code)
	);

	qp_encode_checker enc_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.text      (text),
		.pop       (pop),
		.empty     (empty),
		.code      (code),
		.err_count (err_count),
		.pending   (pending)
	);

	always @(negedge clk) begin
		pop <= steady || ($urandom_range(0, 99) >= 27);
	end

	// entered and left at a falling edge; push stays high between back-to-back items
	task automatic send_item(input logic [7:0] b, input logic [7:0] nx);
		while (!steady && $urandom_range(0, 99) < 27) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		text <= '{text_byte: b, next_byte: nx};
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] t[$]);
		for (int i = 0; i < t.size(); i++) begin
			send_item(t[i], (i + 1 < t.size()) ? t[i + 1] : CH_NUL);
		end
	endtask

	function automatic logic [7:0] pick_byte(input bit long_line);
		int         r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 40)      b = 8'($urandom_range(33, 126));
		else if (r < 52) b = CH_SP;
		else if (r < 56) b = CH_TAB;
		else if (r < 62) b = CH_DOT;
		else if (r < 68) b = CH_DASH;
		else if (r < 71) b = CH_EQ;
		else if (r < 76) b = long_line ? 8'h61 : CH_CR;
		else if (r < 81) b = long_line ? 8'h7A : CH_LF;
		else if (r < 84) b = 8'($urandom_range(1, 31));
		else if (r < 94) b = 8'($urandom_range(127, 255));
		else             b = 8'($urandom_range(33, 126));
		return b;
	endfunction

	initial begin
		#2_400_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int         len;
		int         n;
		logic [7:0] c;
		bit         long_line;
		bit         paused;
		paused = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// dashes at line start, dot rules, control and top bytes, trailing blanks,
		// CR LF merge versus LF CR, and a text ending in a swallowed LF
		msg = '{8'h2D, 8'h2D, 8'h2E, 8'h3D, 8'h01, 8'hFF, 8'h09, 8'h0D, 8'h0A, 8'h2E,
			8'h20, 8'h41, 8'h0A, 8'h0D, 8'h2D, 8'h41, 8'h20, 8'h0A, 8'h7E, 8'h21,
			8'h80, 8'h20};
		send_text(msg);
		msg = '{8'h0D, 8'h0A};
		send_text(msg);
		msg = '{8'h2E};
		send_text(msg);

		while (sent < TEXT_ITEMS) begin
			steady <= (sent >= 120 && sent < 200);
			if (!paused && sent >= 260) begin
				// drain everything before going on
				push <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				// noise: arbitrary bytes with unrelated lookahead
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) begin
					send_item(8'($urandom_range(1, 255)),
						(i == n - 1) ? CH_NUL : 8'($urandom_range(0, 255)));
				end
			end else begin
				long_line = ($urandom_range(0, 3) == 0);
				len = long_line ? $urandom_range(60, 110) : $urandom_range(1, 30);
				msg.delete();
				while (msg.size() < len) begin
					c = pick_byte(long_line);
					msg.push_back(c);
					if (c == CH_CR && $urandom_range(0, 9) < 7) begin
						msg.push_back(CH_LF);
					end
					if ((c == CH_CR || c == CH_LF) && $urandom_range(0, 3) == 0) begin
						msg.push_back($urandom_range(0, 1) ? CH_DOT : CH_DASH);
					end
				end
				send_text(msg);
			end
		end
		push <= 1'b0;

		wait (pending == 0);
		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
